@@ hdl/vroc_pkg.sv @@
// ----------------------------------------------------------------------------
// vroc_pkg
// Shared types, constants and helpers for the record order compare unit.
// ----------------------------------------------------------------------------
package vroc_pkg;

  // field widths
  localparam int DAY_W  = 17;
  localparam int SEC_W  = 37;
  localparam int BL_W   = 16;
  localparam int FREQ_W = 16;
  localparam int POL_W  = 8;

  // time key: day * 86400 * 2^20 + seconds, fits in 55 bits
  localparam int FRAC_BITS   = 20;
  localparam int TIME_W      = 55;
  localparam int DAY_SECONDS = 86400;

  // polarisation key arithmetic
  localparam int PW_W  = 3;
  localparam int PD_W  = 9;
  localparam logic signed [PD_W-1:0] POL_FIRST_SCALE = 9'sd10;
  localparam logic signed [PD_W-1:0] POL_AUTO_BIAS   = 9'sd100;

  // polarisation letters, ASCII
  localparam logic [POL_W-1:0] POL_R = 8'h52;
  localparam logic [POL_W-1:0] POL_L = 8'h4C;
  localparam logic [POL_W-1:0] POL_X = 8'h58;
  localparam logic [POL_W-1:0] POL_Y = 8'h59;

  // result codes
  typedef enum logic [1:0] {
    REL_BEFORE = 2'd0,
    REL_EQUAL  = 2'd1,
    REL_AFTER  = 2'd2
  } relation_t;

  typedef enum logic [2:0] {
    KEY_NONE     = 3'd0,
    KEY_TIME     = 3'd1,
    KEY_CROSS    = 3'd2,
    KEY_BASELINE = 3'd3,
    KEY_FREQ     = 3'd4,
    KEY_POL      = 3'd5
  } key_t;

  // prepared keys handed from the key stage to the decision stage
  typedef struct packed {
    logic [TIME_W-1:0] time_a;
    logic [TIME_W-1:0] time_b;
    logic              cross_a;
    logic              cross_b;
    logic              bl_lt;
    logic              bl_gt;
    logic              freq_lt;
    logic              freq_gt;
    logic              pol_lt;
    logic              pol_gt;
  } keys_t;

  // letter weight: R,L,X,Y map to 1..4, anything else to 0
  function automatic logic [PW_W-1:0] pol_weight(input logic [POL_W-1:0] letter);
    logic [PW_W-1:0] w;
    case (letter)
      POL_R:   w = 3'd1;
      POL_L:   w = 3'd2;
      POL_X:   w = 3'd3;
      POL_Y:   w = 3'd4;
      default: w = 3'd0;
    endcase
    return w;
  endfunction

  // a baseline divisible by 257 is an autocorrelation; 256 = -1 mod 257,
  // so hi*256 + lo is divisible exactly when the two bytes match
  function automatic logic is_cross(input logic [BL_W-1:0] bl);
    return bl[15:8] != bl[7:0];
  endfunction

endpackage

@@ hdl/vroc_key_prep.sv @@
// ----------------------------------------------------------------------------
// vroc_key_prep
// Builds the sort keys of one registered header pair: the exact time keys,
// the cross/auto class and the per-key less/greater flags for the rest.
// ----------------------------------------------------------------------------
module vroc_key_prep
  import vroc_pkg::*;
(
  input  logic [DAY_W-1:0]  day_a,
  input  logic [SEC_W-1:0]  seconds_a,
  input  logic [BL_W-1:0]   baseline_a,
  input  logic [FREQ_W-1:0] freq_a,
  input  logic [POL_W-1:0]  pol_first_a,
  input  logic [POL_W-1:0]  pol_second_a,
  input  logic [DAY_W-1:0]  day_b,
  input  logic [SEC_W-1:0]  seconds_b,
  input  logic [BL_W-1:0]   baseline_b,
  input  logic [FREQ_W-1:0] freq_b,
  input  logic [POL_W-1:0]  pol_first_b,
  input  logic [POL_W-1:0]  pol_second_b,
  output keys_t             keys
);

  logic [TIME_W-1:0]        day_ticks_a;
  logic [TIME_W-1:0]        day_ticks_b;
  logic signed [PD_W-1:0]   w0a, w1a, w0b, w1b;
  logic signed [PD_W-1:0]   pol_diff;
  logic                     cross_a;

  // day offset in 2^-20 second ticks (constant multiply)
  assign day_ticks_a = (TIME_W'(day_a) * TIME_W'(DAY_SECONDS)) << FRAC_BITS;
  assign day_ticks_b = (TIME_W'(day_b) * TIME_W'(DAY_SECONDS)) << FRAC_BITS;

  // letter weights, widened to signed
  assign w0a = $signed(PD_W'(pol_weight(pol_first_a)));
  assign w1a = $signed(PD_W'(pol_weight(pol_second_a)));
  assign w0b = $signed(PD_W'(pol_weight(pol_first_b)));
  assign w1b = $signed(PD_W'(pol_weight(pol_second_b)));

  assign cross_a = is_cross(baseline_a);

  // polarisation difference, parallel hands of autocorrelations pulled forward
  always_comb begin
    pol_diff = POL_FIRST_SCALE * (w0a - w0b) + (w1a - w1b);
    if (!cross_a) begin
      if (pol_first_a == pol_second_a) pol_diff = pol_diff - POL_AUTO_BIAS;
      if (pol_first_b == pol_second_b) pol_diff = pol_diff + POL_AUTO_BIAS;
    end
  end

  // key bundle
  always_comb begin
    keys.time_a  = day_ticks_a + TIME_W'(seconds_a);
    keys.time_b  = day_ticks_b + TIME_W'(seconds_b);
    keys.cross_a = cross_a;
    keys.cross_b = is_cross(baseline_b);
    keys.bl_lt   = baseline_a < baseline_b;
    keys.bl_gt   = baseline_a > baseline_b;
    keys.freq_lt = freq_a < freq_b;
    keys.freq_gt = freq_a > freq_b;
    keys.pol_lt  = pol_diff < 0;
    keys.pol_gt  = pol_diff > 0;
  end

endmodule

@@ hdl/visibility_record_order_compare_unit.sv @@
// ----------------------------------------------------------------------------
// visibility_record_order_compare_unit
// Sort order of two correlator record headers with the key that decided it.
// ----------------------------------------------------------------------------
// Three-stage pipeline: the header pair is registered, the keys are built in
// the middle stage (the day * 86400 * 2^20 constant multiply and seconds add
// sit here), and the last stage does the 55-bit time compare and the key
// priority select into the result register. One beat is accepted per cycle
// while in_stall is low; each beat passes the input, key and result registers
// in that order before its result is presented on the output. The pipeline
// stalls only as far back as a full stage whose successor cannot move.
module visibility_record_order_compare_unit
  import vroc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DAY_W-1:0]  in_day_a,
  input  logic [SEC_W-1:0]  in_seconds_a,
  input  logic [BL_W-1:0]   in_baseline_a,
  input  logic [FREQ_W-1:0] in_freq_a,
  input  logic [POL_W-1:0]  in_pol_first_a,
  input  logic [POL_W-1:0]  in_pol_second_a,
  input  logic [DAY_W-1:0]  in_day_b,
  input  logic [SEC_W-1:0]  in_seconds_b,
  input  logic [BL_W-1:0]   in_baseline_b,
  input  logic [FREQ_W-1:0] in_freq_b,
  input  logic [POL_W-1:0]  in_pol_first_b,
  input  logic [POL_W-1:0]  in_pol_second_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_relation,
  output logic [2:0]        out_deciding_key
);

  logic              in_v_r, key_v_r, res_v_r;
  logic              in_adv, key_adv, res_adv;

  logic [DAY_W-1:0]  day_a_r, day_b_r;
  logic [SEC_W-1:0]  seconds_a_r, seconds_b_r;
  logic [BL_W-1:0]   baseline_a_r, baseline_b_r;
  logic [FREQ_W-1:0] freq_a_r, freq_b_r;
  logic [POL_W-1:0]  pol_first_a_r, pol_second_a_r;
  logic [POL_W-1:0]  pol_first_b_r, pol_second_b_r;

  keys_t             keys_nxt, keys_r;
  relation_t         relation_nxt, relation_r;
  key_t              key_nxt, key_r;

  // stage advance: a stage loads when empty or when its content moves on
  assign res_adv  = !res_v_r || !out_stall;
  assign key_adv  = !key_v_r || res_adv;
  assign in_adv   = !in_v_r || key_adv;
  assign in_stall = !in_adv;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      key_v_r <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      if (in_adv)  in_v_r  <= in_valid;
      if (key_adv) key_v_r <= in_v_r;
      if (res_adv) res_v_r <= key_v_r;
    end
  end

  // input header register
  always_ff @(posedge clk) begin
    if (in_adv && in_valid) begin
      day_a_r        <= in_day_a;
      seconds_a_r    <= in_seconds_a;
      baseline_a_r   <= in_baseline_a;
      freq_a_r       <= in_freq_a;
      pol_first_a_r  <= in_pol_first_a;
      pol_second_a_r <= in_pol_second_a;
      day_b_r        <= in_day_b;
      seconds_b_r    <= in_seconds_b;
      baseline_b_r   <= in_baseline_b;
      freq_b_r       <= in_freq_b;
      pol_first_b_r  <= in_pol_first_b;
      pol_second_b_r <= in_pol_second_b;
    end
  end

  // key build
  vroc_key_prep u_key_prep (
    .day_a        (day_a_r),
    .seconds_a    (seconds_a_r),
    .baseline_a   (baseline_a_r),
    .freq_a       (freq_a_r),
    .pol_first_a  (pol_first_a_r),
    .pol_second_a (pol_second_a_r),
    .day_b        (day_b_r),
    .seconds_b    (seconds_b_r),
    .baseline_b   (baseline_b_r),
    .freq_b       (freq_b_r),
    .pol_first_b  (pol_first_b_r),
    .pol_second_b (pol_second_b_r),
    .keys         (keys_nxt)
  );

  always_ff @(posedge clk) begin
    if (key_adv && in_v_r) keys_r <= keys_nxt;
  end

  // first differing key decides
  always_comb begin
    if (keys_r.time_a < keys_r.time_b) begin
      relation_nxt = REL_BEFORE;
      key_nxt      = KEY_TIME;
    end else if (keys_r.time_a > keys_r.time_b) begin
      relation_nxt = REL_AFTER;
      key_nxt      = KEY_TIME;
    end else if (keys_r.cross_a && !keys_r.cross_b) begin
      relation_nxt = REL_BEFORE;
      key_nxt      = KEY_CROSS;
    end else if (!keys_r.cross_a && keys_r.cross_b) begin
      relation_nxt = REL_AFTER;
      key_nxt      = KEY_CROSS;
    end else if (keys_r.bl_lt) begin
      relation_nxt = REL_BEFORE;
      key_nxt      = KEY_BASELINE;
    end else if (keys_r.bl_gt) begin
      relation_nxt = REL_AFTER;
      key_nxt      = KEY_BASELINE;
    end else if (keys_r.freq_lt) begin
      relation_nxt = REL_BEFORE;
      key_nxt      = KEY_FREQ;
    end else if (keys_r.freq_gt) begin
      relation_nxt = REL_AFTER;
      key_nxt      = KEY_FREQ;
    end else if (keys_r.pol_lt) begin
      relation_nxt = REL_BEFORE;
      key_nxt      = KEY_POL;
    end else if (keys_r.pol_gt) begin
      relation_nxt = REL_AFTER;
      key_nxt      = KEY_POL;
    end else begin
      relation_nxt = REL_EQUAL;
      key_nxt      = KEY_NONE;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (res_adv && key_v_r) begin
      relation_r <= relation_nxt;
      key_r      <= key_nxt;
    end
  end

  assign out_valid        = res_v_r;
  assign out_relation     = relation_r;
  assign out_deciding_key = key_r;

`ifndef ASSERT_OFF
  // equal records and the none key go together
  a_equal_has_no_key: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_relation == REL_EQUAL) |-> (out_deciding_key == KEY_NONE))
    else $error("equal result carries a deciding key");

  a_no_key_is_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_deciding_key == KEY_NONE) |-> (out_relation == REL_EQUAL))
    else $error("result without deciding key is not equal");

  // prepared flags are never both less and greater
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    key_v_r |-> (!(keys_r.bl_lt && keys_r.bl_gt) && !(keys_r.freq_lt && keys_r.freq_gt)
                 && !(keys_r.pol_lt && keys_r.pol_gt)))
    else $error("key flags report both less and greater");

  // an accepted beat lands in the input register
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_v_r)
    else $error("accepted beat lost at input register");
`endif

endmodule

@@ dv/tb_visibility_record_order_compare_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_visibility_record_order_compare_unit
// Self-checking bench for the record order compare unit.
// ----------------------------------------------------------------------------
// Header pairs are driven beat by beat on the input channel. Every accepted
// pair is run through a local sort-order predictor (time, cross/auto class,
// baseline, frequency, polarisation weight), and the expected relation and
// deciding key are queued. Result beats are checked in order against that
// queue. Directed pairs cover field extremes and the corner cases of each key,
// then shaped random pairs run under four sender idle / receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_visibility_record_order_compare_unit
  import vroc_pkg::*;
;

  localparam int          AUTO_MODULUS       = 257;
  localparam int          FIRST_LETTER_SCALE = 10;
  localparam int          PARALLEL_BIAS      = 100;
  localparam logic [63:0] DAY_TICKS          = 64'(DAY_SECONDS) << FRAC_BITS;
  localparam int          WATCHDOG_LIMIT     = 2000;
  localparam int          DRAIN_CYCLES       = 10;
  localparam int          MAX_REPORTS        = 10;
  localparam int          RANDOM_PAIRS       = 232;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [SEC_W-1:0]  seconds;
    logic [BL_W-1:0]   baseline;
    logic [FREQ_W-1:0] freq;
    logic [POL_W-1:0]  pol_first;
    logic [POL_W-1:0]  pol_second;
  } rec_t;

  typedef struct packed {
    relation_t rel;
    key_t      key;
  } order_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [DAY_W-1:0]  in_day_a = '0;
  logic [SEC_W-1:0]  in_seconds_a = '0;
  logic [BL_W-1:0]   in_baseline_a = '0;
  logic [FREQ_W-1:0] in_freq_a = '0;
  logic [POL_W-1:0]  in_pol_first_a = '0;
  logic [POL_W-1:0]  in_pol_second_a = '0;
  logic [DAY_W-1:0]  in_day_b = '0;
  logic [SEC_W-1:0]  in_seconds_b = '0;
  logic [BL_W-1:0]   in_baseline_b = '0;
  logic [FREQ_W-1:0] in_freq_b = '0;
  logic [POL_W-1:0]  in_pol_first_b = '0;
  logic [POL_W-1:0]  in_pol_second_b = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_relation;
  logic [2:0]        out_deciding_key;

  order_t expected_order_q[$];
  int     mismatch_count = 0;
  int     quiet_cycles = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;

  visibility_record_order_compare_unit dut (.*);

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // sort-order predictor
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] record_time(input rec_t r);
    return ((64'(r.day) * 64'(DAY_SECONDS)) << FRAC_BITS) + 64'(r.seconds);
  endfunction

  function automatic int letter_weight(input logic [POL_W-1:0] letter);
    case (letter)
      POL_R:   return 1;
      POL_L:   return 2;
      POL_X:   return 3;
      POL_Y:   return 4;
      default: return 0;
    endcase
  endfunction

  function automatic logic is_auto(input logic [BL_W-1:0] baseline);
    return (int'(baseline) % AUTO_MODULUS) == 0;
  endfunction

  function automatic order_t predict_order(input rec_t a, input rec_t b);
    logic [63:0] time_a;
    logic [63:0] time_b;
    logic        auto_a;
    logic        auto_b;
    int          pol_diff;
    order_t      r;
    time_a = record_time(a);
    time_b = record_time(b);
    auto_a = is_auto(a.baseline);
    auto_b = is_auto(b.baseline);
    pol_diff = FIRST_LETTER_SCALE * (letter_weight(a.pol_first) - letter_weight(b.pol_first))
             + (letter_weight(a.pol_second) - letter_weight(b.pol_second));
    // parallel hands of an autocorrelation sort earlier, raw bytes compared
    if (auto_a) begin
      if (a.pol_first == a.pol_second) pol_diff -= PARALLEL_BIAS;
      if (b.pol_first == b.pol_second) pol_diff += PARALLEL_BIAS;
    end
    r.rel = REL_EQUAL;
    r.key = KEY_NONE;
    if (time_a != time_b) begin
      r.key = KEY_TIME;
      r.rel = (time_a < time_b) ? REL_BEFORE : REL_AFTER;
    end else if (auto_a != auto_b) begin
      // cross-correlations sort first
      r.key = KEY_CROSS;
      r.rel = auto_b ? REL_BEFORE : REL_AFTER;
    end else if (a.baseline != b.baseline) begin
      r.key = KEY_BASELINE;
      r.rel = (a.baseline < b.baseline) ? REL_BEFORE : REL_AFTER;
    end else if (a.freq != b.freq) begin
      r.key = KEY_FREQ;
      r.rel = (a.freq < b.freq) ? REL_BEFORE : REL_AFTER;
    end else if (pol_diff != 0) begin
      r.key = KEY_POL;
      r.rel = (pol_diff < 0) ? REL_BEFORE : REL_AFTER;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // channel monitors
  // ---------------------------------------------------------------------------
  // predict on every accepted input beat
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_order_q.push_back(predict_order(
        '{in_day_a, in_seconds_a, in_baseline_a, in_freq_a, in_pol_first_a, in_pol_second_a},
        '{in_day_b, in_seconds_b, in_baseline_b, in_freq_b, in_pol_first_b, in_pol_second_b}));
    end
  end

  // compare every accepted result beat with the oldest prediction
  always @(posedge clk) begin
    order_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_order_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("[%0t] result beat with nothing expected: relation %0d key %0d",
                   $realtime, out_relation, out_deciding_key);
      end else begin
        want = expected_order_q.pop_front();
        if (out_relation !== want.rel || out_deciding_key !== want.key) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: relation exp %0d got %0d, key exp %0d got %0d",
                     $realtime, want.rel, out_relation, want.key, out_deciding_key);
        end
      end
    end
  end

  // receiver stall, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic rec_t mk_rec(input logic [DAY_W-1:0] day, input logic [SEC_W-1:0] seconds,
                                  input logic [BL_W-1:0] baseline, input logic [FREQ_W-1:0] freq,
                                  input logic [POL_W-1:0] p0, input logic [POL_W-1:0] p1);
    rec_t r;
    r.day        = day;
    r.seconds    = seconds;
    r.baseline   = baseline;
    r.freq       = freq;
    r.pol_first  = p0;
    r.pol_second = p1;
    return r;
  endfunction

  // called and returns at a falling edge
  task automatic send_pair(input rec_t a, input rec_t b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_day_a        <= a.day;
    in_seconds_a    <= a.seconds;
    in_baseline_a   <= a.baseline;
    in_freq_a       <= a.freq;
    in_pol_first_a  <= a.pol_first;
    in_pol_second_a <= a.pol_second;
    in_day_b        <= b.day;
    in_seconds_b    <= b.seconds;
    in_baseline_b   <= b.baseline;
    in_freq_b       <= b.freq;
    in_pol_first_b  <= b.pol_first;
    in_pol_second_b <= b.pol_second;
    in_valid        <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [POL_W-1:0] random_letter();
    case ($urandom_range(0, 5))
      0:       return POL_R;
      1:       return POL_L;
      2:       return POL_X;
      3:       return POL_Y;
      default: return POL_W'($urandom);
    endcase
  endfunction

  // half autocorrelations: equal high and low bytes
  function automatic logic [BL_W-1:0] random_baseline();
    logic [7:0] lo;
    lo = 8'($urandom);
    if ($urandom_range(0, 1)) return {lo, lo};
    return BL_W'($urandom);
  endfunction

  function automatic rec_t random_record();
    rec_t        r;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       r.day = '0;
      1:       r.day = '1;
      default: r.day = DAY_W'($urandom);
    endcase
    // mostly within one day, sometimes the full field
    r.seconds    = ($urandom_range(0, 9) == 0) ? raw[SEC_W-1:0] : SEC_W'(raw % DAY_TICKS);
    r.baseline   = random_baseline();
    r.freq       = ($urandom_range(0, 3) == 0) ? FREQ_W'($urandom_range(0, 3))
                                                : FREQ_W'($urandom);
    r.pol_first  = random_letter();
    r.pol_second = ($urandom_range(0, 2) == 0) ? r.pol_first : random_letter();
    return r;
  endfunction

  task automatic set_pressure(input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_time_order();
    rec_t lo_rec;
    rec_t hi_rec;
    lo_rec = mk_rec('0, '0, 16'h0102, 16'h0000, POL_R, POL_L);
    hi_rec = mk_rec('1, SEC_W'(DAY_TICKS - 1), 16'h0102, 16'h0000, POL_R, POL_L);
    send_pair(lo_rec, hi_rec);
    send_pair(hi_rec, lo_rec);
    // one fraction lsb apart
    send_pair(mk_rec(17'd5000, 37'd1, 16'h0001, 16'd7, POL_X, POL_Y),
              mk_rec(17'd5000, 37'd0, 16'h0001, 16'd7, POL_X, POL_Y));
    // seconds past the end of the day beat the following day
    send_pair(mk_rec(17'd100, '1, 16'h0203, 16'd1, POL_R, POL_R),
              mk_rec(17'd101, '0, 16'h0203, 16'd1, POL_R, POL_R));
    // full day of seconds lands on the next midnight, baseline decides
    send_pair(mk_rec(17'd200, SEC_W'(DAY_TICKS), 16'h0005, 16'd0, POL_L, POL_L),
              mk_rec(17'd201, '0, 16'h0004, 16'd0, POL_L, POL_L));
    // all fields at their maximum on both sides
    send_pair(mk_rec('1, '1, '1, '1, '1, '1), mk_rec('1, '1, '1, '1, '1, '1));
  endtask

  task automatic test_cross_auto();
    send_pair(mk_rec(17'd9, 37'd5, 16'h0000, 16'd3, POL_R, POL_L),
              mk_rec(17'd9, 37'd5, 16'h0001, 16'd3, POL_R, POL_L));
    send_pair(mk_rec(17'd9, 37'd5, 16'h0102, 16'd3, POL_R, POL_L),
              mk_rec(17'd9, 37'd5, 16'h0101, 16'd3, POL_R, POL_L));
    send_pair(mk_rec(17'd9, 37'd5, 16'hFFFF, 16'd3, POL_R, POL_L),
              mk_rec(17'd9, 37'd5, 16'h0000, 16'd3, POL_R, POL_L));
    send_pair(mk_rec(17'd9, 37'd5, 16'd257, 16'd3, POL_X, POL_Y),
              mk_rec(17'd9, 37'd5, 16'd514, 16'd3, POL_X, POL_Y));
    send_pair(mk_rec(17'd9, 37'd5, 16'hFFFE, 16'd3, POL_X, POL_Y),
              mk_rec(17'd9, 37'd5, 16'hFFFD, 16'd3, POL_X, POL_Y));
  endtask

  task automatic test_frequency();
    send_pair(mk_rec(17'd77, 37'd9, 16'h0A0B, 16'h0000, POL_Y, POL_X),
              mk_rec(17'd77, 37'd9, 16'h0A0B, 16'hFFFF, POL_Y, POL_X));
    send_pair(mk_rec(17'd77, 37'd9, 16'h0A0A, 16'hFFFF, POL_Y, POL_Y),
              mk_rec(17'd77, 37'd9, 16'h0A0A, 16'hFFFE, POL_L, POL_R));
  endtask

  task automatic test_polarisation();
    // cross-correlations: plain weights, first letter counted tenfold
    send_pair(mk_rec(17'd3, 37'd1, 16'h1234, 16'd2, POL_R, POL_R),
              mk_rec(17'd3, 37'd1, 16'h1234, 16'd2, POL_L, POL_L));
    send_pair(mk_rec(17'd3, 37'd1, 16'h1234, 16'd2, POL_Y, POL_X),
              mk_rec(17'd3, 37'd1, 16'h1234, 16'd2, POL_Y, POL_L));
    send_pair(mk_rec(17'd3, 37'd1, 16'h1234, 16'd2, POL_R, POL_Y),
              mk_rec(17'd3, 37'd1, 16'h1234, 16'd2, POL_L, POL_R));
    // unknown letters weigh nothing, so the records tie
    send_pair(mk_rec(17'd3, 37'd1, 16'h1234, 16'd2, 8'h41, 8'hFF),
              mk_rec(17'd3, 37'd1, 16'h1234, 16'd2, 8'h00, 8'h00));
    // autocorrelations: parallel hands pushed forward
    send_pair(mk_rec(17'd3, 37'd1, 16'h0303, 16'd2, POL_R, POL_R),
              mk_rec(17'd3, 37'd1, 16'h0303, 16'd2, POL_R, POL_L));
    send_pair(mk_rec(17'd3, 37'd1, 16'h0303, 16'd2, POL_L, POL_R),
              mk_rec(17'd3, 37'd1, 16'h0303, 16'd2, POL_Y, POL_Y));
    send_pair(mk_rec(17'd3, 37'd1, 16'h0000, 16'd2, 8'hFF, 8'hFF),
              mk_rec(17'd3, 37'd1, 16'h0000, 16'd2, 8'h00, 8'h01));
    send_pair(mk_rec(17'd3, 37'd1, 16'h0303, 16'd2, POL_L, POL_L),
              mk_rec(17'd3, 37'd1, 16'h0303, 16'd2, POL_R, POL_R));
    send_pair(mk_rec(17'd3, 37'd1, 16'h0303, 16'd2, POL_X, POL_X),
              mk_rec(17'd3, 37'd1, 16'h0303, 16'd2, POL_X, POL_X));
  endtask

  // pairs that agree up to a chosen key and differ there, plus some noise
  task automatic test_random_pairs(input int count);
    rec_t a;
    rec_t b;
    rec_t c;
    repeat (count) begin
      a = random_record();
      b = a;
      case ($urandom_range(0, 11))
        0: ;
        1, 2: begin
          case ($urandom_range(0, 2))
            0: begin
              c         = random_record();
              b.day     = c.day;
              b.seconds = c.seconds;
            end
            1: b.seconds = $urandom_range(0, 1) ? a.seconds + SEC_W'($urandom_range(1, 3))
                                                : a.seconds - SEC_W'($urandom_range(1, 3));
            default: b.day = a.day ^ DAY_W'(1);
          endcase
        end
        3: b.baseline = random_baseline();
        4: b.baseline = is_auto(a.baseline) ? {2{8'($urandom)}}
                                            : a.baseline + BL_W'($urandom_range(1, 2));
        5, 6: b.freq = $urandom_range(0, 1) ? FREQ_W'($urandom) : a.freq + 16'd1;
        7, 8, 9: begin
          b.pol_first  = random_letter();
          b.pol_second = $urandom_range(0, 1) ? b.pol_first : random_letter();
        end
        default: b = random_record();
      endcase
      send_pair(a, b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    set_pressure(0, 0);
    test_time_order();
    test_cross_auto();
    test_frequency();
    test_polarisation();
    test_random_pairs(RANDOM_PAIRS);
    set_pressure(76, 0);
    test_random_pairs(RANDOM_PAIRS);
    set_pressure(0, 76);
    test_random_pairs(RANDOM_PAIRS);
    set_pressure(38, 38);
    test_random_pairs(RANDOM_PAIRS);

    in_valid <= 1'b0;
    while (expected_order_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
hdl/vroc_pkg.sv
hdl/vroc_key_prep.sv
hdl/visibility_record_order_compare_unit.sv
dv/tb_visibility_record_order_compare_unit.sv
